// File: hdl/dwtdzq_pkg.sv
// Shared types, widths and constants for the wavelet dead-zone quantizer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dwtdzq_pkg;

    // Field and register widths.
    localparam int COEFF_W    = 24;
    localparam int POS_W      = 12;
    localparam int STEP_W     = 13;
    localparam int DZ_W       = 16;
    localparam int DIM_W      = 13;
    localparam int LVL_W      = 4;
    localparam int QV_W       = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Fraction bits of the coefficient; the dead-zone threshold is Q8.8.
    localparam int FRAC_BITS  = 8;

    // Largest frame side and number of levels that the subband search honors.
    localparam logic [DIM_W-1:0] MAX_DIM     = 13'd4096;
    localparam int               LEVEL_LIMIT = 8;

    localparam logic [STEP_W-1:0] STEP_MIN = 13'd1;
    localparam logic [STEP_W-1:0] STEP_MAX = 13'd4096;

    // Product of threshold and step, and the divider geometry.
    localparam int PROD_W     = DZ_W + STEP_W;
    localparam int QUO_W      = 16;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;

    // Saturation limits as magnitudes.
    localparam logic [QUO_W-1:0] POS_LIMIT = 16'd32767;
    localparam logic [QUO_W-1:0] NEG_LIMIT = 16'd32768;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_ZONE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_COUNT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CHROMA_MODE  = 3'd5;

    // Which dead-zone threshold applies to a coefficient.
    typedef enum logic [1:0] {
        DZ_NONE,
        DZ_HALF,
        DZ_FULL
    } dz_class_t;

    typedef struct packed {
        logic [STEP_W-1:0] step_size;
        logic [DZ_W-1:0]   dead_zone;
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [LVL_W-1:0]  level_count;
        logic              chroma_mode;
    } cfg_t;

    typedef struct packed {
        logic [COEFF_W-1:0] mag;
        logic [STEP_W-1:0]  q;
        logic               neg;
        dz_class_t          cls;
        logic               last;
    } prep_t;

    typedef struct packed {
        logic [COEFF_W-1:0] mag;
        logic [PROD_W-1:0]  prod;
        logic [QUO_W-1:0]   n;
        logic [STEP_W-1:0]  q;
        logic               neg;
        dz_class_t          cls;
        logic               last;
    } scale_t;

    typedef struct packed {
        logic [QUO_W-1:0]  dividend;
        logic [STEP_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic [STEP_W-1:0] q;
        logic              neg;
        logic              zeroed;
        logic              last;
    } div_t;

endpackage

`default_nettype wire

// File: hdl/dwtdzq_prep.sv
// First stage: coefficient magnitude, step clamping and subband classification.
// Depends on dwtdzq_pkg.
`default_nettype none

module dwtdzq_prep (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dwtdzq_pkg::cfg_t              cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dwtdzq_pkg::COEFF_W-1:0] coeff,
    input  wire logic [dwtdzq_pkg::POS_W-1:0]   col,
    input  wire logic [dwtdzq_pkg::POS_W-1:0]   row,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output dwtdzq_pkg::prep_t                  out_data
);
    import dwtdzq_pkg::*;

    logic              valid_reg;
    prep_t             data_reg;
    prep_t             data_next;
    logic [DIM_W-1:0]  w_clamped;
    logic [DIM_W-1:0]  h_clamped;
    logic [POS_W-1:0]  hw1;
    logic [POS_W-1:0]  hh1;
    logic [POS_W-1:0]  hw2;
    logic [POS_W-1:0]  hh2;
    logic              lv1;
    logic              lv2;
    logic              dz_active;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        w_clamped = (cfg.frame_width  > MAX_DIM) ? MAX_DIM : cfg.frame_width;
        h_clamped = (cfg.frame_height > MAX_DIM) ? MAX_DIM : cfg.frame_height;
        // Halves of the frame at the first and second level.
        hw1 = w_clamped[DIM_W-1:1];
        hh1 = h_clamped[DIM_W-1:1];
        hw2 = {1'b0, w_clamped[DIM_W-1:2]};
        hh2 = {1'b0, h_clamped[DIM_W-1:2]};
        lv1 = (cfg.level_count != '0);
        lv2 = (cfg.level_count >= 4'd2) && (LEVEL_LIMIT >= 2);
        dz_active = (cfg.dead_zone != '0) && !cfg.chroma_mode;

        data_next.neg  = coeff[COEFF_W-1];
        data_next.mag  = coeff[COEFF_W-1] ? (~coeff + 1'b1) : coeff;
        data_next.last = last;

        if (cfg.step_size < STEP_MIN)
        begin
            data_next.q = STEP_MIN;
        end
        else if (cfg.step_size > STEP_MAX)
        begin
            data_next.q = STEP_MAX;
        end
        else
        begin
            data_next.q = cfg.step_size;
        end

        // Only level-one details and the level-two diagonal band see a dead zone;
        // deeper bands and LL are quantized by plain rounding.
        data_next.cls = DZ_NONE;
        if (dz_active && lv1)
        begin
            if (!(col < hw1 && row < hh1))
            begin
                data_next.cls = (col >= hw1 && row >= hh1) ? DZ_FULL : DZ_HALF;
            end
            else if (lv2 && col >= hw2 && row >= hh2)
            begin
                data_next.cls = DZ_HALF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dwtdzq_scale.sv
// Second stage: threshold times step product and the rounded dividend.
// Depends on dwtdzq_pkg.
`default_nettype none

module dwtdzq_scale (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [dwtdzq_pkg::DZ_W-1:0] dead_zone,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire dwtdzq_pkg::prep_t          in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output dwtdzq_pkg::scale_t              out_data
);
    import dwtdzq_pkg::*;

    logic               valid_reg;
    scale_t             data_reg;
    scale_t             data_next;
    logic [COEFF_W:0]   round_sum;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        // Adding half a step and dropping the fraction bits leaves the integer
        // division by q as the only remaining step of the rounding.
        round_sum = {1'b0, in_data.mag}
                  + (COEFF_W+1)'({in_data.q, {(FRAC_BITS-1){1'b0}}});
        data_next.n    = round_sum[FRAC_BITS +: QUO_W];
        data_next.prod = PROD_W'(dead_zone) * PROD_W'(in_data.q);
        data_next.mag  = in_data.mag;
        data_next.q    = in_data.q;
        data_next.neg  = in_data.neg;
        data_next.cls  = in_data.cls;
        data_next.last = in_data.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dwtdzq_zone.sv
// Third stage: dead-zone decision and divider initialization.
// Depends on dwtdzq_pkg.
`default_nettype none

module dwtdzq_zone (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dwtdzq_pkg::scale_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dwtdzq_pkg::div_t       out_data
);
    import dwtdzq_pkg::*;

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        // The Q8.8 scaling of the threshold cancels the coefficient's fraction
        // bits, so the comparisons work on the raw magnitude.
        case (in_data.cls)
            DZ_FULL: data_next.zeroed = (PROD_W'(in_data.mag) <= in_data.prod);
            DZ_HALF: data_next.zeroed = (PROD_W'({in_data.mag, 1'b0}) <= in_data.prod);
            default: data_next.zeroed = 1'b0;
        endcase
        data_next.dividend = in_data.n;
        data_next.rem      = '0;
        data_next.quo      = '0;
        data_next.q        = in_data.q;
        data_next.neg      = in_data.neg;
        data_next.last     = in_data.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dwtdzq_div_stage.sv
// One stage of the pipelined restoring divider, DIV_BITS quotient bits per stage.
// Depends on dwtdzq_pkg.
`default_nettype none

module dwtdzq_div_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire dwtdzq_pkg::div_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output dwtdzq_pkg::div_t     out_data
);
    import dwtdzq_pkg::*;

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        logic [STEP_W:0] trial;
        data_next = in_data;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            // Bring down the next dividend bit; the remainder stays below q.
            trial = {data_next.rem, data_next.dividend[QUO_W-1]};
            data_next.dividend = {data_next.dividend[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, data_next.q})
            begin
                data_next.rem = STEP_W'(trial - {1'b0, data_next.q});
                data_next.quo = {data_next.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem = trial[STEP_W-1:0];
                data_next.quo = {data_next.quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dwtdzq_out.sv
// Last stage: sign, saturation and the output register of the result stream.
// Depends on dwtdzq_pkg.
`default_nettype none

module dwtdzq_out (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire dwtdzq_pkg::div_t         in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [dwtdzq_pkg::QV_W-1:0]   out_value,
    output logic                          out_last
);
    import dwtdzq_pkg::*;

    logic              valid_reg;
    logic [QV_W-1:0]   value_reg;
    logic [QV_W-1:0]   value_next;
    logic              last_reg;
    logic [QUO_W-1:0]  mag_sat;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        if (in_data.neg)
        begin
            mag_sat = (in_data.quo > NEG_LIMIT) ? NEG_LIMIT : in_data.quo;
        end
        else
        begin
            mag_sat = (in_data.quo > POS_LIMIT) ? POS_LIMIT : in_data.quo;
        end

        if (in_data.zeroed)
        begin
            value_next = '0;
        end
        else if (in_data.neg)
        begin
            value_next = QV_W'(~mag_sat + 1'b1);
        end
        else
        begin
            value_next = QV_W'(mag_sat);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            value_reg <= value_next;
            last_reg  <= in_data.last;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dwt_deadzone_quantizer_core.sv
// Top level of the wavelet dead-zone quantizer: config registers and stage chain.
// Depends on dwtdzq_pkg, dwtdzq_prep, dwtdzq_scale, dwtdzq_zone, dwtdzq_div_stage
// and dwtdzq_out.
`default_nettype none

// The core quantizes one wavelet coefficient per clock cycle while the output
// is not stalled. Each input transaction carries a signed coefficient with 8
// fraction bits and its column and row in the Mallat layout; each produces
// exactly one output transaction holding the signed 16-bit quantized value and
// a copy of the last flag, in input order. In order, one stage finds the
// magnitude, clamps the step and classifies the subband, one forms the
// threshold-times-step product and the rounded dividend, one makes the
// dead-zone decision, four run the restoring divider at four quotient bits per
// stage, and the last saturates into the output register. Every stage has its
// own valid bit and a stage only holds while the stage after it is full and
// stalled, so bubbles are squeezed out and input is taken while a finished
// result waits at the output. Registers are written through cfg_we, cfg_addr
// and cfg_wdata and take effect at once; write them only while the core is
// empty, that is with no transaction inside.

module dwt_deadzone_quantizer_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write port.
    input  wire logic                              cfg_we,
    input  wire logic [dwtdzq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [dwtdzq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Coefficient stream.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // s_axis_tdata: coeff [23:0], col [35:24], row [47:36].
    input  wire logic [47:0]                       s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    // Quantized stream.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // m_axis_tdata: quantized_value [15:0].
    output logic [15:0]                            m_axis_tdata,
    output logic                                   m_axis_tlast
);
    import dwtdzq_pkg::*;

    localparam int PIPE_DEPTH = 4 + DIV_STAGES;

    cfg_t   cfg_reg;

    logic   prep_valid;
    logic   prep_ready;
    prep_t  prep_data;
    logic   scale_valid;
    logic   scale_ready;
    scale_t scale_data;

    logic   div_valid [DIV_STAGES+1];
    logic   div_ready [DIV_STAGES+1];
    div_t   div_data  [DIV_STAGES+1];

    logic [3:0] occ_reg;
    logic [3:0] occ_next;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size    <= 13'd1;
            cfg_reg.dead_zone    <= '0;
            cfg_reg.frame_width  <= 13'd4096;
            cfg_reg.frame_height <= 13'd4096;
            cfg_reg.level_count  <= '0;
            cfg_reg.chroma_mode  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_STEP_SIZE:    cfg_reg.step_size    <= cfg_wdata[STEP_W-1:0];
                REG_DEAD_ZONE:    cfg_reg.dead_zone    <= cfg_wdata[DZ_W-1:0];
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_wdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_wdata[DIM_W-1:0];
                REG_LEVEL_COUNT:  cfg_reg.level_count  <= cfg_wdata[LVL_W-1:0];
                REG_CHROMA_MODE:  cfg_reg.chroma_mode  <= cfg_wdata[0];
                default:          cfg_reg.chroma_mode  <= cfg_reg.chroma_mode;
            endcase
        end
    end

    dwtdzq_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .coeff     (s_axis_tdata[23:0]),
        .col       (s_axis_tdata[35:24]),
        .row       (s_axis_tdata[47:36]),
        .last      (s_axis_tlast),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    dwtdzq_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .dead_zone (cfg_reg.dead_zone),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (scale_valid),
        .out_ready (scale_ready),
        .out_data  (scale_data)
    );

    dwtdzq_zone u_zone (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_data   (scale_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // Divider chain: each stage adds DIV_BITS quotient bits.
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        dwtdzq_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[g]),
            .in_ready  (div_ready[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_ready (div_ready[g+1]),
            .out_data  (div_data[g+1])
        );
    end

    dwtdzq_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_ready  (div_ready[DIV_STAGES]),
        .in_data   (div_data[DIV_STAGES]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    // Count of transactions inside the core, kept for the checks below.
    always_comb
    begin
        occ_next = occ_reg;
        if (s_axis_tvalid && s_axis_tready && !(m_axis_tvalid && m_axis_tready))
        begin
            occ_next = occ_reg + 4'd1;
        end
        else if (!(s_axis_tvalid && s_axis_tready) && m_axis_tvalid && m_axis_tready)
        begin
            occ_next = occ_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // The pipeline never holds more transactions than it has stages.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 4'(PIPE_DEPTH))
        else $error("pipeline holds more transactions than stages");

    // A result is only presented when a transaction is inside the core.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (occ_reg != 4'd0))
        else $error("result presented with no transaction inside");

    // With the output register empty no stage can be holding back input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output register is empty");

endmodule

`default_nettype wire
